### sv/ipf_pkg.sv
`default_nettype none
package ipf_pkg;

	// Default sizes of the prime table, the lane rotation and the stored values.
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int LANES_DEF       = 4;
	localparam int VALUE_WIDTH_DEF = 20;

	// Fixed widths of the beat fields.
	localparam int CAND_W  = 20;
	localparam int RIDX_W  = 10;
	localparam int COUNT_W = 11;
	localparam int LANE_W  = 2;
	localparam int RVAL_W  = 20;

	// The table always holds this value at position zero.
	localparam int FIRST_PRIME = 2;

	// Command codes.
	localparam logic CMD_TEST = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_DIV
	} ipf_state_t;

	// One command beat.
	typedef struct packed {
		logic              command;
		logic [CAND_W-1:0] candidate;
		logic [RIDX_W-1:0] read_index;
	} ipf_item_t;

	// One result beat.
	typedef struct packed {
		logic               is_prime;
		logic               table_full;
		logic [COUNT_W-1:0] prime_count;
		logic [LANE_W-1:0]  holder_lane;
		logic [RVAL_W-1:0]  read_value;
	} ipf_result_t;

endpackage
`default_nettype wire

### sv/ipf_ram.sv
`default_nettype none
module ipf_ram #(
	parameter int WIDTH = ipf_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH = ipf_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// One write port and one read port with the read data registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule
`default_nettype wire

### sv/ipf_rem.sv
`default_nettype none
module ipf_rem #(
	parameter int W = ipf_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic      [W-1:0] rem
);

	localparam int SW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    shifted;
	logic [W-1:0]  rem_next;

	// One restoring step: bring down the next dividend bit and subtract when it fits.
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		if (shifted >= {1'b0, dsr_q}) begin
			rem_next = W'(shifted - {1'b0, dsr_q});
		end else begin
			rem_next = W'(shifted);
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - SW'(1);
				end
			end
		end
	end

	// Working registers of the remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

### sv/incremental_prime_filter_unit.sv
`default_nettype none
// Incremental prime filter.
// A command beat is taken on a clock edge with start high and busy low. A test
// command checks item.candidate against every stored prime, one table entry at
// a time: the entry is fetched from the table memory (ST_FETCH), loaded into
// the remainder unit (ST_LOAD), and its remainder is worked out bit-serially
// (ST_DIV). The walk ends at the first entry that divides the candidate, or
// after the last stored entry. A prime is appended to the table and given the
// next lane of a round-robin over LANES; when the table is full it is reported
// with table_full set and not stored. A read command returns the entry at
// item.read_index (zero when that position holds no prime).
// Each result beat sits on result for one cycle with done high; the receiver
// cannot stall it. A new command may be accepted in the cycle that done is high.
// After reset the table holds only the prime 2 and the count is one; no
// clearing pass is needed.
module incremental_prime_filter_unit #(
	parameter int TABLE_DEPTH = ipf_pkg::TABLE_DEPTH_DEF,
	parameter int LANES       = ipf_pkg::LANES_DEF,
	parameter int VALUE_WIDTH = ipf_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire ipf_pkg::ipf_item_t  item,
	output logic                     busy,
	output logic                     done,
	output ipf_pkg::ipf_result_t     result
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > ipf_pkg::RIDX_W) ? CW : ipf_pkg::RIDX_W;
	localparam int LW   = (LANES > 1) ? $clog2(LANES) : 1;

	ipf_pkg::ipf_state_t  state_q, state_d;
	ipf_pkg::ipf_result_t result_q;
	logic                   done_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          count_q;
	logic [LW-1:0]          lane_q;
	logic                   cmd_q;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic                   rd_ok_q;
	logic                   nz_q;

	logic                   accept;
	logic [AW-1:0]          ram_raddr;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [VALUE_WIDTH-1:0] rdata;
	logic [VALUE_WIDTH-1:0] entry;
	logic                   rem_start;
	logic                   rem_done;
	logic [VALUE_WIDTH-1:0] rem_val;
	logic [CW-1:0]          idx_inc;
	logic [CW-1:0]          count_inc;
	logic                   divides;
	logic                   last_entry;
	logic                   fin_test;
	logic                   fin_read;
	logic                   found;
	logic                   store;

	// Prime table. Position zero is never written and reads as the first prime.
	ipf_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Shared bit-serial remainder unit.
	ipf_rem #(
		.W (VALUE_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (cand_q),
		.divisor  (entry),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// Walk decisions for the entry under test.
	always_comb begin
		accept     = start && (state_q == ipf_pkg::ST_IDLE);
		entry      = (idx_q == '0) ? VALUE_WIDTH'(ipf_pkg::FIRST_PRIME) : rdata;
		idx_inc    = idx_q + CW'(1);
		count_inc  = count_q + CW'(1);
		divides    = nz_q && (rem_val == '0);
		last_entry = (idx_inc == count_q);
		fin_test   = (state_q == ipf_pkg::ST_DIV) && rem_done && (divides || last_entry);
		fin_read   = (state_q == ipf_pkg::ST_LOAD) && (cmd_q == ipf_pkg::CMD_READ);
		found      = fin_test && !divides;
		store      = found && (count_q < CW'(TABLE_DEPTH));
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ipf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ipf_pkg::ST_FETCH;
				end
			end
			ipf_pkg::ST_FETCH: begin
				state_d = ipf_pkg::ST_LOAD;
			end
			ipf_pkg::ST_LOAD: begin
				if (cmd_q == ipf_pkg::CMD_READ) begin
					state_d = ipf_pkg::ST_IDLE;
				end else begin
					state_d = ipf_pkg::ST_DIV;
				end
			end
			ipf_pkg::ST_DIV: begin
				if (rem_done) begin
					state_d = fin_test ? ipf_pkg::ST_IDLE : ipf_pkg::ST_FETCH;
				end
			end
			default: begin
				state_d = ipf_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. The only write lands at the end of a test, before the
	// next fetch of the table, so reads and writes never overlap.
	always_comb begin
		busy      = (state_q != ipf_pkg::ST_IDLE);
		ram_raddr = idx_q[AW-1:0];
		rem_start = (state_q == ipf_pkg::ST_LOAD) && (cmd_q == ipf_pkg::CMD_TEST);
		ram_we    = store;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = cand_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipf_pkg::ST_IDLE;
			done_q  <= 1'b0;
			count_q <= CW'(1);
			lane_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin_test || fin_read;
			if (store) begin
				count_q <= count_inc;
				lane_q  <= (lane_q == LW'(LANES - 1)) ? '0 : lane_q + LW'(1);
			end
		end
	end

	// Command fields, walk index and the result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= item.command;
			cand_q  <= VALUE_WIDTH'(item.candidate);
			rd_ok_q <= CMPW'(item.read_index) < CMPW'(count_q);
			idx_q   <= (item.command == ipf_pkg::CMD_READ) ? CW'(item.read_index) : '0;
		end else if ((state_q == ipf_pkg::ST_DIV) && rem_done && !fin_test) begin
			idx_q <= idx_inc;
		end
		if (state_q == ipf_pkg::ST_LOAD) begin
			nz_q <= (entry != '0);
		end
		if (fin_test) begin
			result_q.is_prime    <= found;
			result_q.table_full  <= found && !store;
			result_q.prime_count <= ipf_pkg::COUNT_W'(store ? count_inc : count_q);
			result_q.holder_lane <= found ? ipf_pkg::LANE_W'(lane_q) : '0;
			result_q.read_value  <= '0;
		end else if (fin_read) begin
			result_q.is_prime    <= 1'b0;
			result_q.table_full  <= 1'b0;
			result_q.prime_count <= ipf_pkg::COUNT_W'(count_q);
			result_q.holder_lane <= '0;
			result_q.read_value  <= rd_ok_q ? ipf_pkg::RVAL_W'(entry) : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result beat is only shown once the sequencer is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted command keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not start the sequencer");

	// The stored count stays between one and the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CW'(TABLE_DEPTH)))
		else $error("stored count out of range");

	// The walk never tests past the last stored entry.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ipf_pkg::ST_DIV) |-> (idx_q < count_q))
		else $error("walk index beyond stored count");

	// A full table is only reported for a prime, and only when the table is full.
	a_full_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.table_full) |-> (result.is_prime && (count_q == CW'(TABLE_DEPTH))))
		else $error("table_full without a prime or with room left");

endmodule
`default_nettype wire
